// ===== hw/rtl/nnpc_pkg.sv =====
`default_nettype none
package nnpc_pkg;

   localparam int MAX_POINTS_DEF = 32;
   localparam int COORD_BITS_DEF = 24;
   localparam int INDEX_BITS_DEF = 16;

   localparam int POS_W   = 5;
   localparam int TOTAL_W = 6;
   localparam int KIND_W  = 2;
   localparam int FLAG_W  = 2;
   localparam int REORDER_MIN = 3;

   typedef enum logic [KIND_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

endpackage
`default_nettype wire

// ===== hw/rtl/nnpc_point_mem.sv =====
`default_nettype none
module nnpc_point_mem #(
   parameter int AW = 5,
   parameter int PW = 88
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [PW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [PW-1:0] rd_data
);

   logic [PW-1:0] mem_ff [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/nnpc_dist.sv =====
`default_nettype none
module nnpc_dist #(
   parameter int CB = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [3*CB-1:0]   a_pos,
   input  wire logic [3*CB-1:0]   b_pos,
   output logic                   done,
   output logic      [2*CB+3:0]   sq_dist
);

   logic [3*CB-1:0]  a_ff, a_in, b_ff, b_in;
   logic [2:0]       step_ff, step_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CB:0]      diff_ff, diff_in;
   logic [2*CB+1:0]  prod_ff, prod_in;
   logic [2*CB+3:0]  acc_ff, acc_in;
   logic [CB-1:0]    ca, cb_v;
   logic signed [CB:0] sd;

   always_comb begin
      ca   = a_ff[CB-1:0];
      cb_v = b_ff[CB-1:0];
      case (step_ff)
         3'd1: begin
            ca   = a_ff[2*CB-1:CB];
            cb_v = b_ff[2*CB-1:CB];
         end
         3'd2: begin
            ca   = a_ff[3*CB-1:2*CB];
            cb_v = b_ff[3*CB-1:2*CB];
         end
         default: begin
            ca   = a_ff[CB-1:0];
            cb_v = b_ff[CB-1:0];
         end
      endcase
      sd = $signed({ca[CB-1], ca}) - $signed({cb_v[CB-1], cb_v});
      diff_in = sd[CB] ? (CB+1)'(-sd) : (CB+1)'(sd);
      prod_in = (2*CB+2)'(diff_ff) * (2*CB+2)'(diff_ff);
      a_in    = a_ff;
      b_in    = b_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      if (start) begin
         a_in    = a_pos;
         b_in    = b_pos;
         step_in = 3'd0;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (step_ff >= 3'd2) begin
            acc_in = acc_ff + (2*CB+4)'(prod_ff);
         end
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign sq_dist = acc_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/nnpc_div.sv =====
`default_nettype none
module nnpc_div #(
   parameter int SW = 30,
   parameter int CW = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [SW-1:0] dividend,
   input  wire logic        [CW-1:0] divisor,
   output logic                      done,
   output logic signed      [SW-1:0] quotient
);

   localparam int NW = $clog2(SW + 1);

   logic [SW-1:0] quo_ff, quo_in;
   logic [CW-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [NW-1:0] left_ff, left_in;
   logic          neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CW:0]   trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[SW-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      left_in = left_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in  = dividend[SW-1];
         quo_in  = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
         left_in = NW'(SW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = CW'(trial);
            quo_in = {quo_ff[SW-2:0], 1'b0};
         end
         left_in = left_ff - NW'(1);
         if (left_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      left_ff <= left_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule
`default_nettype wire

// ===== hw/rtl/nearest_neighbour_point_chain_top.sv =====
// Ordered 3D point list with greedy nearest-neighbour reordering.
// req channel: one request per transfer; tuser carries the request kind
// (append, insert at front, clear), tdata the vertex index and x/y/z.
// rsp channel: after every request the whole list is sent in order, one
// transfer per point, tlast on the final one, each carrying the centroid and
// point count; an empty list gives a single transfer with the empty flag set.
// req_tready is high only while the block is idle; one request is handled
// at a time. Storing an entry shifts the entries from its slot onward up by
// one place through the memory. An insert into a list that already holds 3 or
// more points runs the reorder: about N*N/2 distance evaluations on the single
// distance unit plus the entry shifts. Centroid: the coordinates of all N
// points are summed, then three serial divides by the point count follow.
// Output: each point is read from memory and then sent; a stalled receiver
// simply holds the current transfer.
// Reset empties the list; no memory clearing pass is needed.
`default_nettype none
module nearest_neighbour_point_chain_top #(
   parameter int MAX_POINTS = nnpc_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = nnpc_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS = nnpc_pkg::INDEX_BITS_DEF,
   localparam int PW    = INDEX_BITS + 3*COORD_BITS,
   localparam int REQ_W = ((PW + 7) / 8) * 8,
   localparam int RSP_F = INDEX_BITS + nnpc_pkg::POS_W + nnpc_pkg::TOTAL_W + 3*COORD_BITS,
   localparam int RSP_W = ((RSP_F + 7) / 8) * 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // vertex_index, pos_x, pos_y, pos_z
   input  wire logic [REQ_W-1:0]              req_tdata,
   // req_type
   input  wire logic [nnpc_pkg::KIND_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // point_index, list_position, point_total, centre_x, centre_y, centre_z
   output logic [RSP_W-1:0]                   rsp_tdata,
   // list_empty, refused_full
   output logic [nnpc_pkg::FLAG_W-1:0]        rsp_tuser,
   output logic                               rsp_tlast
);
   import nnpc_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int SW = COORD_BITS + CW;
   localparam int DW = 2*COORD_BITS + 4;
   localparam int CB = COORD_BITS;
   localparam int IB = INDEX_BITS;

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_SHF_RD   = 16'h0002,
      ST_SHF_WR   = 16'h0004,
      ST_RO_ARD   = 16'h0008,
      ST_RO_ALD   = 16'h0010,
      ST_RO_QRD   = 16'h0020,
      ST_RO_QLD   = 16'h0040,
      ST_RO_DIST  = 16'h0080,
      ST_RO_MOVE  = 16'h0100,
      ST_RO_NEXT  = 16'h0200,
      ST_SUM_RD   = 16'h0400,
      ST_SUM_ACC  = 16'h0800,
      ST_DIV_GO   = 16'h1000,
      ST_DIV_WT   = 16'h2000,
      ST_OUT_RD   = 16'h4000,
      ST_OUT_SEND = 16'h8000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] k_ff, k_in, dst_ff, dst_in, p_ff, p_in, q_ff, q_in, bidx_ff, bidx_in;
   logic [PW-1:0] mov_ff, mov_in, anc_ff, anc_in, cand_ff, cand_in, bdat_ff, bdat_in;
   logic [DW-1:0] best_ff, best_in;
   logic          have_ff, have_in, refused_ff, refused_in;
   logic [1:0]    axis_ff, axis_in;
   logic signed [SW-1:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in, div_arg;
   logic [CB-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [PW-1:0] wdata, rdata;
   logic          dist_start, dist_done, div_start, div_done;
   logic [DW-1:0] dist_val;
   logic signed [SW-1:0] div_q;
   logic          accept, rsp_done, empty, last_pt;
   req_kind_type  kind;
   logic [CW-1:0] k_next_cnt, p_next_cnt, q_next_cnt;

   nnpc_point_mem #(.AW(AW), .PW(PW)) u_mem (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   nnpc_dist #(.CB(CB)) u_dist (
      .clock   (clock),
      .reset   (reset),
      .start   (dist_start),
      .a_pos   (anc_ff[PW-1:IB]),
      .b_pos   (rdata[PW-1:IB]),
      .done    (dist_done),
      .sq_dist (dist_val)
   );

   nnpc_div #(.SW(SW), .CW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_arg),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign kind       = req_kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT_SEND);
   assign rsp_done   = rsp_tvalid && rsp_tready;
   assign empty      = (cnt_ff == '0);
   assign k_next_cnt = CW'(k_ff) + CW'(1);
   assign p_next_cnt = CW'(p_ff) + CW'(1);
   assign q_next_cnt = CW'(q_ff) + CW'(1);
   assign last_pt    = empty || (k_next_cnt == cnt_ff);

   always_comb begin
      case (axis_ff)
         2'd1:    div_arg = sy_ff;
         2'd2:    div_arg = sz_ff;
         default: div_arg = sx_ff;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      cnt_in     = cnt_ff;
      k_in       = k_ff;
      dst_in     = dst_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      bidx_in    = bidx_ff;
      mov_in     = mov_ff;
      anc_in     = anc_ff;
      cand_in    = cand_ff;
      bdat_in    = bdat_ff;
      best_in    = best_ff;
      have_in    = have_ff;
      refused_in = refused_ff;
      axis_in    = axis_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      sz_in      = sz_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      we         = 1'b0;
      waddr      = k_ff;
      wdata      = rdata;
      raddr      = k_ff;
      dist_start = 1'b0;
      div_start  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            sx_in = '0;
            sy_in = '0;
            sz_in = '0;
            if (accept) begin
               refused_in = 1'b0;
               k_in       = '0;
               state_in   = ST_SUM_RD;
               case (kind)
                  REQ_CLEAR: begin
                     cnt_in = '0;
                  end
                  REQ_APPEND, REQ_INSERT: begin
                     if (cnt_ff == CW'(MAX_POINTS)) begin
                        refused_in = 1'b1;
                     end else begin
                        mov_in   = req_tdata[PW-1:0];
                        k_in     = AW'(cnt_ff);
                        dst_in   = (kind == REQ_INSERT) ? '0 : AW'(cnt_ff);
                        cnt_in   = cnt_ff + CW'(1);
                        p_in     = '0;
                        ret_in   = ((kind == REQ_INSERT) && (cnt_ff >= CW'(REORDER_MIN)))
                                   ? ST_RO_ARD : ST_SUM_RD;
                        state_in = ST_SHF_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHF_RD: begin
            raddr = k_ff - AW'(1);
            if (k_ff == dst_ff) begin
               we       = 1'b1;
               waddr    = dst_ff;
               wdata    = mov_ff;
               k_in     = '0;
               state_in = ret_ff;
            end else begin
               state_in = ST_SHF_WR;
            end
         end
         ST_SHF_WR: begin
            we       = 1'b1;
            waddr    = k_ff;
            wdata    = rdata;
            k_in     = k_ff - AW'(1);
            state_in = ST_SHF_RD;
         end
         ST_RO_ARD: begin
            raddr    = p_ff;
            state_in = ST_RO_ALD;
         end
         ST_RO_ALD: begin
            anc_in   = rdata;
            q_in     = p_ff + AW'(1);
            have_in  = 1'b0;
            state_in = ST_RO_QRD;
         end
         ST_RO_QRD: begin
            raddr    = q_ff;
            state_in = ST_RO_QLD;
         end
         ST_RO_QLD: begin
            raddr      = q_ff;
            cand_in    = rdata;
            dist_start = 1'b1;
            state_in   = ST_RO_DIST;
         end
         ST_RO_DIST: begin
            raddr = q_ff;
            if (dist_done) begin
               if (!have_ff || (dist_val < best_ff)) begin
                  have_in = 1'b1;
                  best_in = dist_val;
                  bidx_in = q_ff;
                  bdat_in = cand_ff;
               end
               if (q_next_cnt == cnt_ff) begin
                  state_in = ST_RO_MOVE;
               end else begin
                  q_in     = q_ff + AW'(1);
                  state_in = ST_RO_QRD;
               end
            end
         end
         ST_RO_MOVE: begin
            k_in     = bidx_ff;
            dst_in   = p_ff + AW'(1);
            mov_in   = bdat_ff;
            anc_in   = bdat_ff;
            p_in     = p_ff + AW'(1);
            ret_in   = ST_RO_NEXT;
            state_in = ST_SHF_RD;
         end
         ST_RO_NEXT: begin
            if (p_next_cnt < cnt_ff) begin
               q_in     = p_ff + AW'(1);
               have_in  = 1'b0;
               state_in = ST_RO_QRD;
            end else begin
               k_in     = '0;
               state_in = ST_SUM_RD;
            end
         end
         ST_SUM_RD: begin
            if (empty) begin
               state_in = ST_OUT_SEND;
            end else begin
               state_in = ST_SUM_ACC;
            end
         end
         ST_SUM_ACC: begin
            sx_in = sx_ff + SW'($signed(rdata[IB+CB-1:IB]));
            sy_in = sy_ff + SW'($signed(rdata[IB+2*CB-1:IB+CB]));
            sz_in = sz_ff + SW'($signed(rdata[IB+3*CB-1:IB+2*CB]));
            if (k_next_cnt == cnt_ff) begin
               axis_in  = 2'd0;
               state_in = ST_DIV_GO;
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = ST_SUM_RD;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WT;
         end
         ST_DIV_WT: begin
            if (div_done) begin
               case (axis_ff)
                  2'd1:    cy_in = CB'(div_q);
                  2'd2:    cz_in = CB'(div_q);
                  default: cx_in = CB'(div_q);
               endcase
               if (axis_ff == 2'd2) begin
                  k_in     = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp_done) begin
               if (last_pt) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ff     <= ST_SUM_RD;
         cnt_ff     <= '0;
         refused_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         cnt_ff     <= cnt_in;
         refused_ff <= refused_in;
      end
      k_ff    <= k_in;
      dst_ff  <= dst_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      bidx_ff <= bidx_in;
      mov_ff  <= mov_in;
      anc_ff  <= anc_in;
      cand_ff <= cand_in;
      bdat_ff <= bdat_in;
      best_ff <= best_in;
      have_ff <= have_in;
      axis_ff <= axis_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      sz_ff   <= sz_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
   end

   always_comb begin
      if (empty) begin
         rsp_tdata = '0;
      end else begin
         rsp_tdata = RSP_W'({cz_ff, cy_ff, cx_ff, TOTAL_W'(cnt_ff), POS_W'(k_ff),
                             rdata[IB-1:0]});
      end
   end

   assign rsp_tuser = {refused_ff, empty};
   assign rsp_tlast = last_pt;

endmodule
`default_nettype wire
